>>> design/rsh_pkg.sv
// Shared constants for the rectangle/sector hit test: parameter defaults,
// arctangent table in turn units and fixed-point sizes.
// No dependencies.
`timescale 1ns / 1ps

package rsh_pkg;

   localparam int COORD_WIDTH_DEF      = 16;
   localparam int ANGLE_WIDTH_DEF      = 16;
   localparam int ANGLE_ITERATIONS_DEF = 16;

   // CORDIC operands carry this many fraction bits
   localparam int FRAC_BITS  = 16;
   // turn accumulator width, 0x80000000 is a half turn
   localparam int TURN_WIDTH = 32;
   localparam int ATAN_DEPTH = 24;
   localparam int ATAN_IDX_W = 5;

   localparam logic [TURN_WIDTH-1:0] HALF_TURN = 32'h8000_0000;

   localparam logic [TURN_WIDTH-1:0] ATAN_TURN [ATAN_DEPTH] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

endpackage

>>> design/rect_sector_hit_test.sv
// Top level of the rectangle/sector hit test: the sample-walk sequencer.
// Uses rsh_pkg, rsh_mod and rsh_point.
`timescale 1ns / 1ps

// One query at a time: start is taken while busy is low, busy stays high
// until the answer goes out, and rsp_valid pulses for one cycle with rsp_hit.
// The receiver cannot stall; the word must be captured in that cycle. Every
// sample point goes through one point unit, which stops after the reach-box
// test for a point outside the box and after the radius test for one inside
// the box but past the radius, and runs the CORDIC loop for a point that
// needs an angle. The four corners come first; the grid walk then uses the
// serial remainder unit to place the first column and row, and steps one
// column at a time. The number of sample points grows with the square of
// reach / step when no point hits.
module rect_sector_hit_test #(
   parameter int COORD_WIDTH      = rsh_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH      = rsh_pkg::ANGLE_WIDTH_DEF,
   parameter int ANGLE_ITERATIONS = rsh_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_rect_left,
   input  logic signed [COORD_WIDTH-1:0] req_rect_top,
   input  logic signed [COORD_WIDTH-1:0] req_rect_right,
   input  logic signed [COORD_WIDTH-1:0] req_rect_bottom,
   input  logic signed [COORD_WIDTH-1:0] req_centre_x,
   input  logic signed [COORD_WIDTH-1:0] req_centre_y,
   input  logic [COORD_WIDTH-2:0]        req_reach,
   input  logic [ANGLE_WIDTH-1:0]        req_start_angle,
   input  logic [ANGLE_WIDTH-1:0]        req_end_angle,
   input  logic [COORD_WIDTH-1:0]        req_sample_step,
   output logic                          rsp_valid,
   output logic                          rsp_hit
);

   import rsh_pkg::*;

   localparam int C  = COORD_WIDTH;
   localparam int XW = COORD_WIDTH + 2;
   localparam int NW = COORD_WIDTH + 1;
   localparam int SW = COORD_WIDTH - 1;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b0000_0000_0001,
      S_CORNER = 12'b0000_0000_0010,
      S_PWAIT  = 12'b0000_0000_0100,
      S_XSET   = 12'b0000_0000_1000,
      S_XMOD   = 12'b0000_0001_0000,
      S_YSET   = 12'b0000_0010_0000,
      S_YMOD   = 12'b0000_0100_0000,
      S_COL    = 12'b0000_1000_0000,
      S_ROW    = 12'b0001_0000_0000,
      S_NEXT   = 12'b0010_0000_0000,
      S_DONE   = 12'b0100_0000_0000,
      S_LAUNCH = 12'b1000_0000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic signed [C-1:0]    l_ff, t_ff, r_ff, b_ff, cx_ff, cy_ff;
   logic [SW-1:0]          reach_ff;
   logic [ANGLE_WIDTH-1:0] lo_ff, hi_ff;
   logic [SW-1:0]          s_ff, s_in;
   logic [1:0]             corner_ff, corner_in;
   logic                   grid_ff, grid_in;
   logic                   hit_ff, hit_in;
   logic signed [XW-1:0]   x_ff, x_in;
   logic signed [XW-1:0]   y0_ff, y0_in;
   logic signed [XW-1:0]   y_ff, y_in;
   logic signed [C-1:0]    px_ff, px_in;
   logic signed [C-1:0]    py_ff, py_in;

   logic                   accept;
   logic [SW-1:0]          half;
   logic signed [XW-1:0]   reach_x;
   logic signed [XW-1:0]   lo_x, hi_x, lo_y, hi_y;
   logic signed [XW-1:0]   xe, ye;
   logic signed [XW-1:0]   num_x, num_y;
   logic signed [XW-1:0]   pad;
   logic                   mod_start;
   logic [NW-1:0]          mod_num;
   logic                   mod_done;
   logic [SW-1:0]          mod_rem;
   logic                   pt_start;
   logic                   pt_done;
   logic                   pt_hit;

   assign accept  = start && (state_ff == S_IDLE);
   assign half    = req_reach >> 1;
   assign reach_x = XW'($signed({1'b0, reach_ff}));
   assign lo_x    = XW'(cx_ff) - reach_x;
   assign hi_x    = XW'(cx_ff) + reach_x;
   assign lo_y    = XW'(cy_ff) - reach_x;
   assign hi_y    = XW'(cy_ff) + reach_x;
   assign xe      = (x_ff > XW'(r_ff)) ? XW'(r_ff) : x_ff;
   assign ye      = (y_ff > XW'(b_ff)) ? XW'(b_ff) : y_ff;
   assign num_x   = lo_x - XW'(l_ff);
   assign num_y   = lo_y - XW'(t_ff);
   // step forward to the next grid position at or past the reach edge
   assign pad     = (mod_rem == '0) ? '0 : XW'($signed({1'b0, s_ff - mod_rem}));

   always_comb begin
      state_in  = state_ff;
      s_in      = s_ff;
      corner_in = corner_ff;
      grid_in   = grid_ff;
      hit_in    = hit_ff;
      x_in      = x_ff;
      y0_in     = y0_ff;
      y_in      = y_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      mod_start = 1'b0;
      mod_num   = '0;
      pt_start  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               s_in      = (req_sample_step > C'(half)) ? half : req_sample_step[SW-1:0];
               if (s_in == '0) begin
                  s_in = SW'(1);
               end
               corner_in = '0;
               grid_in   = 1'b0;
               hit_in    = 1'b0;
               state_in  = S_CORNER;
            end
         end
         S_CORNER: begin
            px_in    = corner_ff[1] ? r_ff : l_ff;
            py_in    = corner_ff[0] ? b_ff : t_ff;
            state_in = S_LAUNCH;
         end
         S_LAUNCH: begin
            pt_start = 1'b1;
            state_in = S_PWAIT;
         end
         S_PWAIT: begin
            if (pt_done) begin
               if (pt_hit) begin
                  hit_in   = 1'b1;
                  state_in = S_DONE;
               end else if (!grid_ff) begin
                  if (corner_ff != 2'd3) begin
                     corner_in = corner_ff + 2'd1;
                     state_in  = S_CORNER;
                  end else if (l_ff <= r_ff && t_ff <= b_ff) begin
                     grid_in  = 1'b1;
                     state_in = S_XSET;
                  end else begin
                     state_in = S_DONE;
                  end
               end else if (y_ff >= XW'(b_ff) || ye > hi_y) begin
                  state_in = S_NEXT;
               end else begin
                  y_in     = y_ff + XW'($signed({1'b0, s_ff}));
                  state_in = S_ROW;
               end
            end
         end
         S_XSET: begin
            if (lo_x <= XW'(l_ff)) begin
               x_in     = XW'(l_ff);
               state_in = S_YSET;
            end else begin
               mod_start = 1'b1;
               mod_num   = num_x[NW-1:0];
               state_in  = S_XMOD;
            end
         end
         S_XMOD: begin
            if (mod_done) begin
               x_in     = lo_x + pad;
               state_in = S_YSET;
            end
         end
         S_YSET: begin
            if (lo_y <= XW'(t_ff)) begin
               y0_in    = XW'(t_ff);
               state_in = S_COL;
            end else begin
               mod_start = 1'b1;
               mod_num   = num_y[NW-1:0];
               state_in  = S_YMOD;
            end
         end
         S_YMOD: begin
            if (mod_done) begin
               y0_in    = lo_y + pad;
               state_in = S_COL;
            end
         end
         S_COL: begin
            if (xe >= lo_x && xe <= hi_x) begin
               y_in     = y0_ff;
               state_in = S_ROW;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_ROW: begin
            px_in    = xe[C-1:0];
            py_in    = ye[C-1:0];
            state_in = S_LAUNCH;
         end
         S_NEXT: begin
            if (x_ff >= XW'(r_ff) || xe > hi_x) begin
               state_in = S_DONE;
            end else begin
               x_in     = x_ff + XW'($signed({1'b0, s_ff}));
               state_in = S_COL;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (accept) begin
         l_ff     <= req_rect_left;
         t_ff     <= req_rect_top;
         r_ff     <= req_rect_right;
         b_ff     <= req_rect_bottom;
         cx_ff    <= req_centre_x;
         cy_ff    <= req_centre_y;
         reach_ff <= req_reach;
         lo_ff    <= req_start_angle;
         hi_ff    <= req_end_angle;
      end
      s_ff      <= s_in;
      corner_ff <= corner_in;
      grid_ff   <= grid_in;
      hit_ff    <= hit_in;
      x_ff      <= x_in;
      y0_ff     <= y0_in;
      y_ff      <= y_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
   end

   rsh_mod #(
      .NUM_W (NW),
      .DEN_W (SW)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .num   (mod_num),
      .den   (s_ff),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   rsh_point #(
      .COORD_WIDTH      (COORD_WIDTH),
      .ANGLE_WIDTH      (ANGLE_WIDTH),
      .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
   ) u_point (
      .clock (clock),
      .reset (reset),
      .start (pt_start),
      .px    (px_ff),
      .py    (py_ff),
      .cx    (cx_ff),
      .cy    (cy_ff),
      .reach (reach_ff),
      .lo    (lo_ff),
      .hi    (hi_ff),
      .done  (pt_done),
      .hit   (pt_hit)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_hit   = hit_ff;

`ifndef SYNTH
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted word");
   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("block did not return to idle after the result word");
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result word outside a query");
   a_no_launch_in_mod: assert property (@(posedge clock) disable iff (reset)
      mod_start |-> !pt_start)
      else $error("point unit and remainder unit started together");
`endif

endmodule

>>> design/rsh_mod.sv
// Bit-serial remainder unit: num mod den, one numerator bit per cycle.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps

module rsh_mod #(
   parameter int NUM_W = 17,
   parameter int DEN_W = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [DEN_W-1:0] rem
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;

   always_comb begin
      shifted = {rem_ff, num_ff[NUM_W-1]};
      diff    = shifted - {1'b0, den};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         num_in  = num;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         rem_in = (shifted >= {1'b0, den}) ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

>>> design/rsh_cordic.sv
// Vectoring CORDIC: angle of (dx, dy) in turn units, one rotation per cycle
// through a single shift/add unit. Uses rsh_pkg for the arctangent table.
`timescale 1ns / 1ps

module rsh_cordic #(
   parameter int DW         = rsh_pkg::COORD_WIDTH_DEF + 1,
   parameter int ANGLE_W    = rsh_pkg::ANGLE_WIDTH_DEF,
   parameter int ITERATIONS = rsh_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [DW-1:0] dx,
   input  logic signed [DW-1:0] dy,
   output logic                done,
   output logic [ANGLE_W-1:0]  angle
);

   import rsh_pkg::*;

   // room for the fraction bits and the CORDIC gain
   localparam int CW = DW + FRAC_BITS + 3;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [ATAN_IDX_W-1:0]   cnt_ff, cnt_in;
   logic signed [CW-1:0]    x_ff, x_in;
   logic signed [CW-1:0]    y_ff, y_in;
   logic [TURN_WIDTH-1:0]   z_ff, z_in;
   logic signed [CW-1:0]    x_init, y_init;
   logic signed [CW-1:0]    xs, ys;
   logic [TURN_WIDTH-1:0]   z_round;

   always_comb begin
      x_init  = CW'(dx) <<< FRAC_BITS;
      y_init  = CW'(dy) <<< FRAC_BITS;
      xs      = x_ff >>> cnt_ff;
      ys      = y_ff >>> cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         // turn left half-plane vectors by a half turn first
         if (dx < 0) begin
            x_in = -x_init;
            y_in = -y_init;
            z_in = HALF_TURN;
         end else begin
            x_in = x_init;
            y_in = y_init;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + ATAN_TURN[cnt_ff];
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - ATAN_TURN[cnt_ff];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ATAN_IDX_W'(ITERATIONS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   // round to nearest at the output width
   assign z_round = z_ff + (TURN_WIDTH'(1) << (TURN_WIDTH - 1 - ANGLE_W));
   assign angle   = z_round[TURN_WIDTH-1 -: ANGLE_W];
   assign done    = done_ff;

endmodule

>>> design/rsh_point.sv
// Single sample point test: reach box, squared distance on one shared
// multiplier, then angle range via rsh_cordic. Uses rsh_pkg.
`timescale 1ns / 1ps

module rsh_point #(
   parameter int COORD_WIDTH      = rsh_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH      = rsh_pkg::ANGLE_WIDTH_DEF,
   parameter int ANGLE_ITERATIONS = rsh_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [COORD_WIDTH-1:0] px,
   input  logic signed [COORD_WIDTH-1:0] py,
   input  logic signed [COORD_WIDTH-1:0] cx,
   input  logic signed [COORD_WIDTH-1:0] cy,
   input  logic [COORD_WIDTH-2:0]        reach,
   input  logic [ANGLE_WIDTH-1:0]        lo,
   input  logic [ANGLE_WIDTH-1:0]        hi,
   output logic                          done,
   output logic                          hit
);

   import rsh_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * COORD_WIDTH;

   typedef enum logic [7:0] {
      P_IDLE  = 8'b0000_0001,
      P_CHECK = 8'b0000_0010,
      P_SQX   = 8'b0000_0100,
      P_SQY   = 8'b0000_1000,
      P_SQR   = 8'b0001_0000,
      P_ANGLE = 8'b0010_0000,
      P_RANGE = 8'b0100_0000,
      P_FIN   = 8'b1000_0000
   } pstate_type;

   pstate_type            state_ff, state_in;
   logic signed [DW-1:0]  dx_ff, dx_in;
   logic signed [DW-1:0]  dy_ff, dy_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [PW-1:0]         acc_ff, acc_in;
   logic                  hit_ff, hit_in;
   logic                  cordic_start;
   logic                  cordic_done;
   logic [ANGLE_WIDTH-1:0] angle;
   logic signed [DW-1:0]  reach_s;
   logic signed [DW-1:0]  mul_a;
   logic signed [2*DW-1:0] mul_p;
   logic                  out_box;
   logic                  in_range;
   logic [1:0]            mul_sel;

   localparam logic [1:0] MUL_DX = 2'd0;
   localparam logic [1:0] MUL_DY = 2'd1;
   localparam logic [1:0] MUL_R  = 2'd2;

   assign reach_s = DW'($signed({1'b0, reach}));
   assign out_box = (dx_ff > reach_s) || (-dx_ff > reach_s) ||
                    (dy_ff > reach_s) || (-dy_ff > reach_s);
   assign in_range = (lo <= hi) ? (angle >= lo && angle <= hi)
                                : (angle <= hi || angle >= lo);

   // shared squarer
   always_comb begin
      case (mul_sel)
         MUL_DX:  mul_a = dx_ff;
         MUL_DY:  mul_a = dy_ff;
         default: mul_a = reach_s;
      endcase
      mul_p = mul_a * mul_a;
   end

   always_comb begin
      state_in     = state_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      hit_in       = hit_ff;
      cordic_start = 1'b0;
      mul_sel      = MUL_DX;
      unique case (state_ff)
         P_IDLE: begin
            if (start) begin
               dx_in    = DW'(px) - DW'(cx);
               dy_in    = DW'(cy) - DW'(py);
               hit_in   = 1'b0;
               state_in = P_CHECK;
            end
         end
         P_CHECK: begin
            mul_sel = MUL_DX;
            prod_in = mul_p[PW-1:0];
            if (out_box || (dx_ff == '0 && dy_ff == '0)) begin
               state_in = P_FIN;
            end else begin
               state_in = P_SQX;
            end
         end
         P_SQX: begin
            mul_sel  = MUL_DY;
            prod_in  = mul_p[PW-1:0];
            acc_in   = prod_ff;
            state_in = P_SQY;
         end
         P_SQY: begin
            mul_sel  = MUL_R;
            prod_in  = mul_p[PW-1:0];
            acc_in   = acc_ff + prod_ff;
            state_in = P_SQR;
         end
         P_SQR: begin
            if (acc_ff > prod_ff) begin
               state_in = P_FIN;
            end else begin
               cordic_start = 1'b1;
               state_in     = P_ANGLE;
            end
         end
         P_ANGLE: begin
            if (cordic_done) begin
               state_in = P_RANGE;
            end
         end
         P_RANGE: begin
            hit_in   = in_range;
            state_in = P_FIN;
         end
         P_FIN: begin
            state_in = P_IDLE;
         end
         default: state_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      hit_ff  <= hit_in;
   end

   rsh_cordic #(
      .DW         (DW),
      .ANGLE_W    (ANGLE_WIDTH),
      .ITERATIONS (ANGLE_ITERATIONS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .dx    (dx_ff),
      .dy    (dy_ff),
      .done  (cordic_done),
      .angle (angle)
   );

   assign done = (state_ff == P_FIN);
   assign hit  = hit_ff;

endmodule

>>> tb/tb_rect_sector_hit_test.sv
// Testbench for rect_sector_hit_test: drives query words, predicts the hit
// bit of each query with no fixed answer by a behavioral sample walk and
// CORDIC angle, and checks every answer. Depends on rsh_pkg and the RTL.
`timescale 1ns / 1ps

module tb_rect_sector_hit_test;
   import rsh_pkg::*;

   localparam int NUM_RANDOM = 630;
   localparam longint CYCLE_LIMIT = 100_000_000;

   typedef struct {
      logic signed [15:0] left, top, right, bottom, cx, cy;
      logic [14:0]        reach;
      logic [15:0]        lo_ang, hi_ang, step;
      int                 want;   // -1: take the predicted answer
   } query_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [15:0] req_rect_left = '0, req_rect_top = '0;
   logic signed [15:0] req_rect_right = '0, req_rect_bottom = '0;
   logic signed [15:0] req_centre_x = '0, req_centre_y = '0;
   logic [14:0]        req_reach = '0;
   logic [15:0]        req_start_angle = '0, req_end_angle = '0, req_sample_step = '0;
   logic               rsp_valid, rsp_hit;

   bit                 hit_queue[$];
   int                 error_count = 0;
   longint             cycle_count = 0;
   int                 idle_pct = 0;

   rect_sector_hit_test dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_rect_left(req_rect_left), .req_rect_top(req_rect_top),
      .req_rect_right(req_rect_right), .req_rect_bottom(req_rect_bottom),
      .req_centre_x(req_centre_x), .req_centre_y(req_centre_y),
      .req_reach(req_reach), .req_start_angle(req_start_angle),
      .req_end_angle(req_end_angle), .req_sample_step(req_sample_step),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] turn_angle(longint dx, longint dy);
      longint x, y, xs, ys;
      logic [31:0] z;
      x = dx * 65536;
      y = dy * 65536;
      z = '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = HALF_TURN;
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_TURN[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_TURN[i];
         end
      end
      z = z + 32'h0000_8000;
      return z[31:16];
   endfunction

   function automatic bit in_sector(longint px, longint py, query_type q);
      longint dx, dy, r;
      logic [15:0] a;
      r = longint'(q.reach);
      dx = px - longint'(q.cx);
      dy = longint'(q.cy) - py;
      if (dx > r || -dx > r || dy > r || -dy > r) return 1'b0;
      if (dx == 0 && dy == 0) return 1'b0;
      if (dx * dx + dy * dy > r * r) return 1'b0;
      a = turn_angle(dx, dy);
      if (q.lo_ang <= q.hi_ang) return a >= q.lo_ang && a <= q.hi_ang;
      return a <= q.hi_ang || a >= q.lo_ang;
   endfunction

   function automatic longint first_index(longint org, longint lo, longint s);
      if (lo <= org) return 0;
      return (lo - org + s - 1) / s;
   endfunction

   function automatic bit predict_hit(query_type q);
      longint l, t, r, b, s, x, y, xe, ye, cx, cy, rad;
      bit hit;
      l = longint'(q.left); t = longint'(q.top);
      r = longint'(q.right); b = longint'(q.bottom);
      cx = longint'(q.cx); cy = longint'(q.cy); rad = longint'(q.reach);
      s = longint'(q.step);
      if (s > rad / 2) s = rad / 2;
      if (s < 1) s = 1;
      hit = in_sector(l, t, q) || in_sector(l, b, q) || in_sector(r, t, q) ||
            in_sector(r, b, q);
      if (!hit && l <= r && t <= b) begin
         x = l + first_index(l, cx - rad, s) * s;
         while (!hit) begin
            xe = x > r ? r : x;
            if (xe >= cx - rad && xe <= cx + rad) begin
               y = t + first_index(t, cy - rad, s) * s;
               while (!hit) begin
                  ye = y > b ? b : y;
                  if (in_sector(xe, ye, q)) hit = 1'b1;
                  if (y >= b || ye > cy + rad) break;
                  y += s;
               end
            end
            if (x >= r || xe > cx + rad) break;
            x += s;
         end
      end
      return hit;
   endfunction

   function automatic int rand_span(int lim);
      return int'($urandom_range(2 * lim)) - lim;
   endfunction

   function automatic query_type random_query();
      query_type q;
      int kind, r, c;
      kind = $urandom_range(99);
      q.lo_ang = 16'($urandom);
      q.hi_ang = 16'($urandom);
      q.want = -1;
      if (kind < 55) begin
         r = $urandom_range(12);
         q.step = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8));
      end else if (kind < 85) begin
         r = $urandom_range(400);
         q.step = 16'(r / 8 + $urandom_range(r + 1));
      end else begin
         r = $urandom_range(32767);
         // keep the grid over a large radius to a bounded number of points
         q.step = ($urandom_range(1) == 0) ? 16'($urandom_range(65535, r / 16 + 1))
                                           : 16'(r / 4 + 1);
      end
      q.reach = 15'(r);
      if (kind >= 95) begin
         // unconstrained coordinates, including wrap-prone extremes
         q.cx = 16'($urandom); q.cy = 16'($urandom);
         q.left = 16'($urandom); q.top = 16'($urandom);
         q.right = 16'($urandom); q.bottom = 16'($urandom);
      end else begin
         c = r + 4;
         q.cx = 16'(rand_span(16000));
         q.cy = 16'(rand_span(16000));
         q.left = 16'(int'(q.cx) + rand_span(2 * c));
         q.top = 16'(int'(q.cy) + rand_span(2 * c));
         q.right = 16'(int'(q.left) + $urandom_range(3 * c));
         q.bottom = 16'(int'(q.top) + $urandom_range(3 * c));
         if ($urandom_range(9) == 0) begin
            q.right = 16'(int'(q.left) - 1 - $urandom_range(c));
         end
         if ($urandom_range(9) == 0) begin
            q.bottom = 16'(int'(q.top) - 1 - $urandom_range(c));
         end
      end
      return q;
   endfunction

   function automatic query_type make_row(int l, int t, int r, int b, int cx, int cy,
                                          int rad, int lo, int hi, int s, int want);
      query_type q;
      q.left = 16'(l); q.top = 16'(t); q.right = 16'(r); q.bottom = 16'(b);
      q.cx = 16'(cx); q.cy = 16'(cy); q.reach = 15'(rad);
      q.lo_ang = 16'(lo); q.hi_ang = 16'(hi); q.step = 16'(s);
      q.want = want;
      return q;
   endfunction

   // Present one word at the current edge and hold it until taken.
   task automatic send_query(query_type q);
      start <= 1'b1;
      req_rect_left <= q.left;     req_rect_top <= q.top;
      req_rect_right <= q.right;   req_rect_bottom <= q.bottom;
      req_centre_x <= q.cx;        req_centre_y <= q.cy;
      req_reach <= q.reach;        req_start_angle <= q.lo_ang;
      req_end_angle <= q.hi_ang;   req_sample_step <= q.step;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      hit_queue.push_back(q.want >= 0 ? bit'(q.want) : predict_hit(q));
   endtask

   task automatic idle_gap();
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // Check answers and bound the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (hit_queue.size() == 0) begin
            $error("unexpected answer word, hit=%0b", rsp_hit);
            error_count++;
         end else begin
            bit want_hit;
            want_hit = hit_queue.pop_front();
            if (rsp_hit !== want_hit) begin
               $error("field hit: expected %0b, got %0b", want_hit, rsp_hit);
               error_count++;
            end
         end
      end
   end

   initial begin
      query_type rows[$];
      int phase;
      rows.push_back(make_row(0, 0, 20, 20, 10, 10, 0, 0, 65535, 1, 0));
      rows.push_back(make_row(5, 5, 5, 5, 5, 5, 100, 0, 65535, 3, 0));
      rows.push_back(make_row(1000, 1000, 1200, 1200, 0, 0, 50, 0, 65535, 4, 0));
      rows.push_back(make_row(-32768, -32768, 32767, 32767, 0, 0, 32767, 0, 65535,
                              65535, 1));
      rows.push_back(make_row(-32768, -32768, 32767, 32767, -32768, 32767, 32767,
                              0, 65535, 0, -1));
      rows.push_back(make_row(-32768, -32768, -32768, -32768, 32767, 32767, 32767,
                              0, 65535, 1, 0));
      rows.push_back(make_row(-5, -5, 5, 5, 0, 0, 3, 60000, 2000, 1, -1));
      rows.push_back(make_row(-5, -5, 5, 5, 0, 0, 3, 16384, 16384, 1, -1));
      rows.push_back(make_row(-5, -5, 5, 5, 0, 0, 3, 16383, 16385, 1, -1));
      rows.push_back(make_row(-5, -5, 5, 5, 0, 0, 3, 32768, 32768, 1, -1));
      rows.push_back(make_row(5, 5, -5, -5, 0, 0, 8, 0, 65535, 1, -1));
      rows.push_back(make_row(5, -5, -5, 5, 0, 0, 4, 0, 65535, 1, 0));
      rows.push_back(make_row(-20, -20, 20, 20, 0, 0, 1, 0, 65535, 65535, 1));
      rows.push_back(make_row(-20, -20, 20, 20, 0, 0, 10, 49152, 49152, 0, -1));
      rows.push_back(make_row(3, -2, 9, 2, 0, 0, 6, 65000, 500, 2, -1));
      rows.push_back(make_row(-9, -9, 9, 9, 0, 0, 9, 40000, 30000, 7, -1));
      rows.push_back(make_row(32760, -32768, 32767, -32760, 32767, -32768, 32767,
                              0, 65535, 65535, -1));
      rows.push_back(make_row(0, 0, 0, 0, 1, 0, 1, 32768, 32768, 1, -1));
      rows.push_back(make_row(0, 0, 0, 0, 0, 1, 1, 16384, 16384, 1, -1));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_query(rows[i]);

      for (int n = 0; n < NUM_RANDOM; n++) begin
         phase = n * 4 / NUM_RANDOM;
         idle_pct = (phase == 1) ? 76 : (phase == 3) ? 21 : 0;
         if (n == NUM_RANDOM / 2) begin
            // drain everything before carrying on
            start <= 1'b0;
            while (hit_queue.size() != 0) @(posedge clock);
         end
         send_query(random_query());
         idle_gap();
      end
      start <= 1'b0;

      while (hit_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
